/* rtl/vnp_pkg.sv */
// Shared types and constants for the labeled VPN route list parser.
// No dependencies; every other file in rtl/ imports this package.
package vnp_pkg;

  // Entry layout
  localparam int MAX_PREFIX_BYTES = 16;
  localparam int V4_PREFIX_BYTES  = 4;
  localparam int PID_BYTES        = 4;
  localparam int LABEL_BYTES      = 3;
  localparam int RD_BYTES         = 8;
  localparam int HDR_BYTES        = LABEL_BYTES + RD_BYTES;
  localparam int HDR_BITS         = HDR_BYTES * 8;
  localparam int STORE_BYTES      = 16;
  localparam int STORE_BITS       = STORE_BYTES * 8;
  localparam int CNT_W            = 6;   // holds up to ceil(255/8) = 32

  // Front to back queue
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // Configuration port
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;
  localparam logic [1:0] REG_SESSION_UP     = 2'd0;
  localparam logic [1:0] REG_PATH_ID_ENABLE = 2'd1;
  localparam logic [1:0] REG_ADDRESS_FAMILY = 2'd2;

  // Result codes
  localparam logic       KIND_ENTRY  = 1'b0;
  localparam logic       KIND_STATUS = 1'b1;
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_SHORT     = 3'd1;
  localparam logic [2:0] ST_FAMILY    = 3'd2;
  localparam logic [2:0] ST_TRUNC     = 3'd3;
  localparam logic [2:0] ST_TRUNC_PID = 3'd4;

  typedef enum logic [1:0] {
    PH_PATHID,
    PH_LEN,
    PH_BODY,
    PH_SKIP
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_packet;
    logic       withdraw;
  } in_item_t;

  typedef struct packed {
    logic        kind;
    logic [2:0]  status;
    logic        is_withdraw;
    logic [31:0] path_id;
    logic [7:0]  prefix_bits;
    logic [23:0] label_bytes;
    logic [63:0] route_dist;
    logic [63:0] prefix_high;
    logic [63:0] prefix_low;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic session_up;
    logic path_id_enable;
    logic address_family;
  } cfg_t;

  // One queue record: what a single byte produced (entry, status or both)
  typedef struct packed {
    logic        has_entry;
    logic        has_status;
    logic [2:0]  status;
    logic        withdraw;
    logic [31:0] path_id;
    logic [7:0]  prefix_bits;
    logic [23:0] label_bytes;
    logic [63:0] route_dist;
    logic [63:0] prefix_high;
    logic [63:0] prefix_low;
  } rec_t;

endpackage

/* rtl/vnp_regs.sv */
// APB-style configuration registers: session_up, path_id_enable, address_family.
// Depends on vnp_pkg.
module vnp_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [vnp_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [vnp_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [vnp_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready,
  output vnp_pkg::cfg_t                  cfg
);
  import vnp_pkg::*;

  cfg_t       cfg_r, cfg_nxt;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];
  assign cfg     = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (reg_idx)
        REG_SESSION_UP:     cfg_nxt.session_up     = pwdata[0];
        REG_PATH_ID_ENABLE: cfg_nxt.path_id_enable = pwdata[0];
        REG_ADDRESS_FAMILY: cfg_nxt.address_family = pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_SESSION_UP:     prdata = {{(CFG_DATA_W-1){1'b0}}, cfg_r.session_up};
      REG_PATH_ID_ENABLE: prdata = {{(CFG_DATA_W-1){1'b0}}, cfg_r.path_id_enable};
      REG_ADDRESS_FAMILY: prdata = {{(CFG_DATA_W-1){1'b0}}, cfg_r.address_family};
      default:            prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

/* rtl/vnp_front.sv */
// Front end: accepts one list byte per beat, tracks the entry phase and
// builds a queue record for each byte that completes an entry or ends a packet.
// Depends on vnp_pkg.
module vnp_front (
  input  logic              clk,
  input  logic              rst_n,
  input  vnp_pkg::cfg_t     cfg,
  input  logic              in_push,
  input  vnp_pkg::in_item_t in_data,
  input  logic              q_full,
  output logic              q_push,
  output vnp_pkg::rec_t     q_rec
);
  import vnp_pkg::*;

  phase_t                 phase_r, phase_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [CNT_W-1:0]       ent_r, ent_nxt;
  logic [2:0]             err_r, err_nxt;
  logic                   pend_r, pend_nxt;
  logic                   in_pkt_r, in_pkt_nxt;
  logic                   act_r, act_nxt;
  logic                   pid_r, pid_nxt;
  logic                   af_r, af_nxt;
  logic [31:0]            id_r, id_nxt;
  logic [7:0]             len_r, len_nxt;
  logic [23:0]            label_r, label_nxt;
  logic [63:0]            dist_r, dist_nxt;
  logic [STORE_BITS-1:0]  pfx_r, pfx_nxt;

  logic                   accept;
  logic                   start;
  logic                   act, pid, af;
  phase_t                 phase_cur;
  logic [CNT_W-1:0]       cnt_cur;
  logic [CNT_W-1:0]       limit;
  logic [CNT_W-1:0]       pfx_idx;
  logic                   emit_entry;
  logic [7:0]             b;
  logic                   eop;

  assign accept = in_push && !q_full;
  assign b      = in_data.data_byte;
  assign eop    = in_data.end_of_packet;

  always_comb begin
    // Registers latch at the first byte of a packet
    start     = !in_pkt_r;
    act       = start ? cfg.session_up     : act_r;
    pid       = start ? cfg.path_id_enable : pid_r;
    af        = start ? cfg.address_family : af_r;
    phase_cur = start ? (pid ? PH_PATHID : PH_LEN) : phase_r;
    cnt_cur   = start ? '0 : cnt_r;
    limit     = af ? CNT_W'(MAX_PREFIX_BYTES) : CNT_W'(V4_PREFIX_BYTES);
    pfx_idx   = cnt_cur - CNT_W'(HDR_BYTES);

    in_pkt_nxt = in_pkt_r;
    act_nxt    = act_r;
    pid_nxt    = pid_r;
    af_nxt     = af_r;
    phase_nxt  = phase_r;
    cnt_nxt    = cnt_r;
    ent_nxt    = ent_r;
    err_nxt    = err_r;
    pend_nxt   = pend_r;
    id_nxt     = id_r;
    len_nxt    = len_r;
    label_nxt  = label_r;
    dist_nxt   = dist_r;
    pfx_nxt    = pfx_r;
    emit_entry = 1'b0;
    q_rec      = '0;

    if (accept) begin
      in_pkt_nxt = 1'b1;
      act_nxt    = act;
      pid_nxt    = pid;
      af_nxt     = af;
      phase_nxt  = phase_cur;
      cnt_nxt    = cnt_cur;
      err_nxt    = start ? ST_OK : err_r;
      pend_nxt   = start ? 1'b0  : pend_r;

      if (act) begin
        unique case (phase_cur)
          PH_PATHID: begin
            id_nxt  = {id_r[23:0], b};
            cnt_nxt = cnt_cur + 1'b1;
            if (cnt_nxt >= CNT_W'(PID_BYTES)) begin
              cnt_nxt   = '0;
              phase_nxt = PH_LEN;
              if (eop) err_nxt = ST_TRUNC;
            end else if (eop) begin
              err_nxt = ST_TRUNC_PID;
            end
          end
          PH_LEN: begin
            len_nxt   = b;
            label_nxt = '0;
            dist_nxt  = '0;
            pfx_nxt   = '0;
            if (b < 8'(HDR_BITS)) begin
              err_nxt   = ST_SHORT;
              phase_nxt = PH_SKIP;
            end else begin
              ent_nxt   = CNT_W'(({1'b0, b} + 9'd7) >> 3);
              cnt_nxt   = '0;
              pend_nxt  = (ent_nxt - CNT_W'(HDR_BYTES)) > limit;
              phase_nxt = PH_BODY;
              if (eop) err_nxt = ST_TRUNC;
            end
          end
          PH_BODY: begin
            if (cnt_cur < CNT_W'(LABEL_BYTES)) begin
              label_nxt = {label_r[15:0], b};
            end else if (cnt_cur < CNT_W'(HDR_BYTES)) begin
              dist_nxt = {dist_r[55:0], b};
            end else if (pfx_idx < CNT_W'(STORE_BYTES)) begin
              // left-aligned byte lanes, lane 0 at the top
              for (int j = 0; j < STORE_BYTES; j++) begin
                if (pfx_idx[3:0] == 4'(j)) begin
                  pfx_nxt[STORE_BITS-1-8*j -: 8] = pfx_r[STORE_BITS-1-8*j -: 8] | b;
                end
              end
            end
            cnt_nxt = cnt_cur + 1'b1;
            if (cnt_nxt >= ent_r) begin
              if (pend_r) begin
                err_nxt   = ST_FAMILY;
                phase_nxt = PH_SKIP;
              end else begin
                emit_entry = 1'b1;
                cnt_nxt    = '0;
                phase_nxt  = pid ? PH_PATHID : PH_LEN;
              end
            end else if (eop) begin
              err_nxt = ST_TRUNC;
            end
          end
          PH_SKIP: ;
          default: ;
        endcase
      end

      q_rec.has_entry   = emit_entry;
      q_rec.has_status  = eop;
      q_rec.status      = act ? err_nxt : ST_OK;
      q_rec.withdraw    = in_data.withdraw;
      q_rec.path_id     = pid ? id_nxt : '0;
      q_rec.prefix_bits = len_nxt - 8'(HDR_BITS);
      q_rec.label_bytes = label_nxt;
      q_rec.route_dist  = dist_nxt;
      q_rec.prefix_high = pfx_nxt[STORE_BITS-1 -: 64];
      q_rec.prefix_low  = pfx_nxt[63:0];

      if (eop) begin
        in_pkt_nxt = 1'b0;
        err_nxt    = ST_OK;
        pend_nxt   = 1'b0;
        cnt_nxt    = '0;
        phase_nxt  = PH_PATHID;
      end
    end
  end

  assign q_push = accept && (emit_entry || eop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_PATHID;
      cnt_r    <= '0;
      ent_r    <= '0;
      err_r    <= ST_OK;
      pend_r   <= 1'b0;
      in_pkt_r <= 1'b0;
      act_r    <= 1'b0;
      pid_r    <= 1'b0;
      af_r     <= 1'b0;
      id_r     <= '0;
      len_r    <= '0;
      label_r  <= '0;
      dist_r   <= '0;
      pfx_r    <= '0;
    end else begin
      phase_r  <= phase_nxt;
      cnt_r    <= cnt_nxt;
      ent_r    <= ent_nxt;
      err_r    <= err_nxt;
      pend_r   <= pend_nxt;
      in_pkt_r <= in_pkt_nxt;
      act_r    <= act_nxt;
      pid_r    <= pid_nxt;
      af_r     <= af_nxt;
      id_r     <= id_nxt;
      len_r    <= len_nxt;
      label_r  <= label_nxt;
      dist_r   <= dist_nxt;
      pfx_r    <= pfx_nxt;
    end
  end

endmodule

/* rtl/vnp_fifo.sv */
// Short record queue between the front end and the result stage.
// Depends on vnp_pkg (rec_t, QUEUE_DEPTH).
module vnp_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  vnp_pkg::rec_t push_rec,
  input  logic          pop,
  output vnp_pkg::rec_t head,
  output logic          full,
  output logic          empty
);
  import vnp_pkg::*;

  rec_t              slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]   count_r, count_nxt;
  logic              do_push, do_pop;

  assign full    = (count_r == (QPTR_W+1)'(QUEUE_DEPTH));
  assign empty   = (count_r == '0);
  assign head    = slot_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + (QPTR_W+1)'(do_push) - (QPTR_W+1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

/* rtl/vnp_back.sv */
// Result stage: expands each queue record into an entry result and/or a
// status result and holds the oldest one in the output register.
// Depends on vnp_pkg.
module vnp_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_empty,
  input  vnp_pkg::rec_t      q_head,
  output logic               q_pop,
  output logic               out_empty,
  input  logic               out_pop,
  output vnp_pkg::out_item_t out_data
);
  import vnp_pkg::*;

  out_item_t out_r, out_nxt;
  logic      valid_r, valid_nxt;
  logic      sub_r, sub_nxt;   // entry half of the head record already sent
  logic      load;
  logic      taken;

  assign taken     = out_pop && valid_r;
  assign load      = !q_empty && (!valid_r || taken);
  assign out_empty = !valid_r;
  assign out_data  = out_r;

  always_comb begin
    out_nxt   = out_r;
    valid_nxt = valid_r && !taken;
    sub_nxt   = sub_r;
    q_pop     = 1'b0;
    if (load) begin
      valid_nxt           = 1'b1;
      out_nxt.is_withdraw = q_head.withdraw;
      if (q_head.has_entry && !sub_r) begin
        out_nxt.kind        = KIND_ENTRY;
        out_nxt.status      = ST_OK;
        out_nxt.path_id     = q_head.path_id;
        out_nxt.prefix_bits = q_head.prefix_bits;
        out_nxt.label_bytes = q_head.label_bytes;
        out_nxt.route_dist  = q_head.route_dist;
        out_nxt.prefix_high = q_head.prefix_high;
        out_nxt.prefix_low  = q_head.prefix_low;
        out_nxt.last        = !q_head.has_status;
        if (q_head.has_status) begin
          sub_nxt = 1'b1;
        end else begin
          q_pop = 1'b1;
        end
      end else begin
        out_nxt.kind        = KIND_STATUS;
        out_nxt.status      = q_head.status;
        out_nxt.path_id     = '0;
        out_nxt.prefix_bits = '0;
        out_nxt.label_bytes = '0;
        out_nxt.route_dist  = '0;
        out_nxt.prefix_high = '0;
        out_nxt.prefix_low  = '0;
        out_nxt.last        = 1'b1;
        sub_nxt             = 1'b0;
        q_pop               = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      sub_r   <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      sub_r   <= sub_nxt;
    end
  end

endmodule

/* rtl/vpn_nlri_entry_parser.sv */
// Labeled VPN route list parser, top level. One list byte per beat, one
// result per beat out; a byte that closes an entry and the packet gives two.
// A result passes from the front end through the record queue into the output
// register, and a second result from the same byte follows it there.
// Throughput: one byte per cycle while the four-record queue has room; the
// queue drains one result per cycle as out_pop takes them. Reset (rst_n low,
// synchronous) clears the registers, parser state, queue and output valid flag.
module vpn_nlri_entry_parser (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_push,
  output logic                           in_full,
  input  vnp_pkg::in_item_t              in_data,
  output logic                           out_empty,
  input  logic                           out_pop,
  output vnp_pkg::out_item_t             out_data,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [vnp_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [vnp_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [vnp_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready
);
  import vnp_pkg::*;

  cfg_t cfg;
  logic q_push, q_pop, q_full, q_empty;
  rec_t q_rec, q_head;

  assign in_full = q_full;

  vnp_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  vnp_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .in_push (in_push),
    .in_data (in_data),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_rec   (q_rec)
  );

  vnp_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_rec (q_rec),
    .pop      (q_pop),
    .head     (q_head),
    .full     (q_full),
    .empty    (q_empty)
  );

  vnp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

endmodule

/* tb/sv/nlri_result_checker.sv */
`timescale 1ns / 100ps
// Result checker for vpn_nlri_entry_parser: snoops config writes and byte beats,
// predicts the entry/status results and compares every popped result beat.
// Depends on vnp_pkg.
module nlri_result_checker
  import vnp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_push,
  input  logic                  in_full,
  input  in_item_t              in_data,
  input  logic                  out_empty,
  input  logic                  out_pop,
  input  out_item_t             out_data,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic                  pready,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output int                    fail_count,
  output int                    outstanding
);

  // register copies, and the copies latched at the first byte of a packet
  logic        cfg_session, cfg_pid, cfg_v6;
  logic        pkt_open, pkt_active, pkt_pid, pkt_v6;
  logic        family_over;
  phase_t      step;
  logic [7:0]  cnt, entry_len, len_bits;
  logic [2:0]  err;
  logic [31:0] pid_acc;
  logic [23:0] label_acc;
  logic [63:0] rd_acc;
  logic [63:0] pfx_acc [2];

  out_item_t expected_results [$];

  function automatic phase_t entry_start();
    if (pkt_pid) return PH_PATHID;
    return PH_LEN;
  endfunction

  function automatic out_item_t entry_result(input logic wd);
    out_item_t r;
    r = '0;
    r.kind        = KIND_ENTRY;
    r.status      = ST_OK;
    r.is_withdraw = wd;
    r.path_id     = pkt_pid ? pid_acc : 32'd0;
    r.prefix_bits = len_bits - 8'(HDR_BITS);
    r.label_bytes = label_acc;
    r.route_dist  = rd_acc;
    r.prefix_high = pfx_acc[0];
    r.prefix_low  = pfx_acc[1];
    return r;
  endfunction

  task automatic parse_list_byte(input in_item_t beat);
    out_item_t  res [$];
    out_item_t  st;
    logic [7:0] b;
    logic       eop;
    int         limit;
    int         k;
    b   = beat.data_byte;
    eop = beat.end_of_packet;
    if (!pkt_open) begin
      pkt_open    = 1'b1;
      pkt_active  = cfg_session;
      pkt_pid     = cfg_pid;
      pkt_v6      = cfg_v6;
      err         = ST_OK;
      family_over = 1'b0;
      cnt         = '0;
      step        = entry_start();
    end
    if (pkt_active) begin
      case (step)
        PH_PATHID: begin
          pid_acc = {pid_acc[23:0], b};
          cnt++;
          if (cnt >= PID_BYTES) begin
            cnt  = '0;
            step = PH_LEN;
            if (eop) err = ST_TRUNC;
          end else if (eop) begin
            err = ST_TRUNC_PID;
          end
        end
        PH_LEN: begin
          limit      = pkt_v6 ? MAX_PREFIX_BYTES : V4_PREFIX_BYTES;
          len_bits   = b;
          label_acc  = '0;
          rd_acc     = '0;
          pfx_acc[0] = '0;
          pfx_acc[1] = '0;
          if (b < HDR_BITS) begin
            err  = ST_SHORT;
            step = PH_SKIP;
          end else begin
            entry_len   = 8'((int'(b) + 7) / 8);
            cnt         = '0;
            // too long for the family: keep counting, flag when the entry completes
            family_over = (int'(entry_len) - HDR_BYTES) > limit;
            step        = PH_BODY;
            if (eop) err = ST_TRUNC;
          end
        end
        PH_BODY: begin
          if (cnt < LABEL_BYTES) begin
            label_acc = {label_acc[15:0], b};
          end else if (cnt < HDR_BYTES) begin
            rd_acc = {rd_acc[55:0], b};
          end else begin
            k = int'(cnt) - HDR_BYTES;
            if (k < STORE_BYTES) pfx_acc[k / 8] |= 64'(b) << (56 - 8 * (k % 8));
          end
          cnt++;
          if (cnt >= entry_len) begin
            if (family_over) begin
              err  = ST_FAMILY;
              step = PH_SKIP;
            end else begin
              res.push_back(entry_result(beat.withdraw));
              cnt  = '0;
              step = entry_start();
            end
          end else if (eop) begin
            err = ST_TRUNC;
          end
        end
        default: ;
      endcase
    end
    if (eop) begin
      st             = '0;
      st.kind        = KIND_STATUS;
      st.status      = pkt_active ? err : ST_OK;
      st.is_withdraw = beat.withdraw;
      res.push_back(st);
      pkt_open    = 1'b0;
      err         = ST_OK;
      family_over = 1'b0;
      cnt         = '0;
      step        = PH_PATHID;
    end
    if (res.size() > 0) res[res.size() - 1].last = 1'b1;
    foreach (res[i]) expected_results.push_back(res[i]);
  endtask

  task automatic compare_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      cfg_session = 1'b0;
      cfg_pid     = 1'b0;
      cfg_v6      = 1'b0;
      pkt_open    = 1'b0;
      pkt_active  = 1'b0;
      pkt_pid     = 1'b0;
      pkt_v6      = 1'b0;
      family_over = 1'b0;
      step        = PH_PATHID;
      cnt         = '0;
      entry_len   = '0;
      len_bits    = '0;
      err         = ST_OK;
      pid_acc     = '0;
      label_acc   = '0;
      rd_acc      = '0;
      pfx_acc[0]  = '0;
      pfx_acc[1]  = '0;
      expected_results.delete();
      fail_count  = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_SESSION_UP:     cfg_session = pwdata[0];
          REG_PATH_ID_ENABLE: cfg_pid     = pwdata[0];
          REG_ADDRESS_FAMILY: cfg_v6      = pwdata[0];
          default: ;
        endcase
      end
      if (in_push && !in_full) parse_list_byte(in_data);
      if (out_pop && !out_empty) begin
        if (expected_results.size() == 0) begin
          $error("result beat with nothing expected: kind %0d status %0d",
                 out_data.kind, out_data.status);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          compare_field("kind", want.kind, out_data.kind);
          compare_field("status", want.status, out_data.status);
          compare_field("is_withdraw", want.is_withdraw, out_data.is_withdraw);
          compare_field("path_id", want.path_id, out_data.path_id);
          compare_field("prefix_bits", want.prefix_bits, out_data.prefix_bits);
          compare_field("label_bytes", want.label_bytes, out_data.label_bytes);
          compare_field("route_dist", want.route_dist, out_data.route_dist);
          compare_field("prefix_high", want.prefix_high, out_data.prefix_high);
          compare_field("prefix_low", want.prefix_low, out_data.prefix_low);
          compare_field("last", want.last, out_data.last);
        end
      end
    end
    outstanding = expected_results.size();
  end

endmodule

/* tb/sv/vpn_nlri_entry_parser_tb.sv */
`timescale 1ns / 100ps
// Top of the vpn_nlri_entry_parser testbench: clock, reset, config writes,
// route list packets and result popping; checking lives in nlri_result_checker.
// Depends on vnp_pkg, vpn_nlri_entry_parser and nlri_result_checker.
module vpn_nlri_entry_parser_tb;
  import vnp_pkg::*;

  localparam int STALL_LIMIT = 3000;
  localparam int HOLD_CYCLES = 160;
  localparam int PHASE_BYTES = 110;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_push;
  logic                  in_full;
  in_item_t              in_data;
  logic                  out_empty;
  logic                  out_pop;
  out_item_t             out_data;
  logic                  psel, penable, pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;
  int                    fail_count;
  int                    outstanding;
  int                    bytes_sent = 0;
  int                    stall_cycles = 0;
  logic [7:0]            pkt_bytes [$];
  logic                  calm;

  // {session_up, path_id_enable, address_family} per random phase
  logic [2:0] plan [8] = '{3'b100, 3'b111, 3'b010, 3'b110,
                           3'b101, 3'b001, 3'b111, 3'b100};

  // no idling on either side for a stretch of the run
  assign calm = bytes_sent >= 650 && bytes_sent < 800;

  vpn_nlri_entry_parser dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_data   (in_data),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  nlri_result_checker chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_push     (in_push),
    .in_full     (in_full),
    .in_data     (in_data),
    .out_empty   (out_empty),
    .out_pop     (out_pop),
    .out_data    (out_data),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .pready      (pready),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_push && !in_full) || (out_pop && !out_empty)) begin
        stall_cycles <= 0;
      end else if (stall_cycles + 1 >= STALL_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  // result side: random stalls, one long hold-off to back the block up
  initial begin
    int  hold_left;
    bit  held_off;
    hold_left = 0;
    held_off  = 1'b0;
    out_pop   = 1'b0;
    forever begin
      @(negedge clk);
      if (!held_off && bytes_sent >= 500) begin
        held_off  = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_pop <= 1'b0;
      end else if (calm) begin
        out_pop <= 1'b1;
      end else begin
        out_pop <= ($urandom_range(99) >= 11);
      end
    end
  end

  task automatic push_byte(input in_item_t beat);
    while (!calm && $urandom_range(99) < 11) begin
      in_push <= 1'b0;
      @(negedge clk);
    end
    in_push <= 1'b1;
    in_data <= beat;
    @(posedge clk);
    while (in_full) @(posedge clk);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_packet();
    in_item_t beat;
    foreach (pkt_bytes[i]) begin
      beat.data_byte     = pkt_bytes[i];
      beat.end_of_packet = (i == pkt_bytes.size() - 1);
      beat.withdraw      = 1'($urandom_range(1));
      push_byte(beat);
    end
  endtask

  task automatic add_entry(input int len, input bit with_pid);
    if (with_pid) repeat (PID_BYTES) pkt_bytes.push_back(8'($urandom_range(255)));
    pkt_bytes.push_back(8'(len));
    if (len >= HDR_BITS) repeat ((len + 7) / 8) pkt_bytes.push_back(8'($urandom_range(255)));
  endtask

  // mostly well-formed lists; some short or over-long lengths, cut or padded tails
  task automatic build_packet(input bit with_pid, input bit v6);
    int entries, limit, len, pick, cut;
    pkt_bytes.delete();
    limit   = v6 ? MAX_PREFIX_BYTES : V4_PREFIX_BYTES;
    entries = $urandom_range(1, 3);
    for (int e = 0; e < entries; e++) begin
      pick = $urandom_range(99);
      if (pick < 8) len = HDR_BITS;
      else if (pick < 16) len = HDR_BITS + 8 * limit;
      else if (pick < 80) len = $urandom_range(HDR_BITS, HDR_BITS + 8 * limit);
      else if (pick < 88) len = $urandom_range(0, HDR_BITS - 1);
      else len = $urandom_range(HDR_BITS + 8 * limit + 1, 255);
      add_entry(len, with_pid);
      if (pick >= 80) break;
    end
    pick = $urandom_range(99);
    if (pick < 12 && pkt_bytes.size() > 1) begin
      cut = $urandom_range(1, pkt_bytes.size() - 1);
      repeat (cut) void'(pkt_bytes.pop_back());
    end else if (pick < 18) begin
      repeat ($urandom_range(1, 3)) pkt_bytes.push_back(8'($urandom_range(255)));
    end
  endtask

  task automatic write_reg(input logic [1:0] idx, input bit val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {31'd0, val};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
  endtask

  // registers change only with nothing in flight
  task automatic apply_cfg(input bit session, input bit with_pid, input bit v6);
    in_push <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (6) @(negedge clk);
    write_reg(REG_SESSION_UP, session);
    write_reg(REG_PATH_ID_ENABLE, with_pid);
    write_reg(REG_ADDRESS_FAMILY, v6);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  initial begin
    int phase_start;
    rst_n   = 1'b0;
    in_push = 1'b0;
    in_data = '0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // session down: only a done status
    apply_cfg(1'b0, 1'b0, 1'b0);
    pkt_bytes = {8'h5A};
    send_packet();

    // length below 88, over-long ipv4 cut at the length, minimal full entry
    apply_cfg(1'b1, 1'b0, 1'b0);
    pkt_bytes = {8'h57};
    send_packet();
    pkt_bytes = {8'hFF};
    send_packet();
    pkt_bytes = {8'd88};
    repeat (HDR_BYTES) pkt_bytes.push_back(8'hFF);
    send_packet();

    // packet ends inside the path id, then right after it
    apply_cfg(1'b1, 1'b1, 1'b1);
    pkt_bytes = {8'h00, 8'hFF};
    send_packet();
    pkt_bytes = {8'hFF, 8'h00, 8'hFF, 8'h00};
    send_packet();

    foreach (plan[p]) begin
      apply_cfg(plan[p][2], plan[p][1], plan[p][0]);
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < PHASE_BYTES) begin
        build_packet(plan[p][1], plan[p][0]);
        send_packet();
      end
    end

    in_push <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
